/* rtl/core/qspd_pkg.sv */
`default_nettype none

package qspd_pkg;

   // length limits and counter widths
   localparam int NameLimit      = 255;
   localparam int ValueLimit     = 1023;
   localparam int NameLenWidth   = $clog2(NameLimit + 1);
   localparam int ValueLenWidth  = $clog2(ValueLimit + 1);

   // bundle queue between front and back
   localparam int QueueDepth     = 4;
   localparam int QueuePtrWidth  = $clog2(QueueDepth);
   localparam int QueueCntWidth  = $clog2(QueueDepth + 1);

   // result kinds
   localparam logic [2:0] KindName      = 3'd0;
   localparam logic [2:0] KindNameEnd   = 3'd1;
   localparam logic [2:0] KindValue     = 3'd2;
   localparam logic [2:0] KindPairEnd   = 3'd3;
   localparam logic [2:0] KindPairEmpty = 3'd4;

   // up to three results caused by one input transfer
   typedef struct packed {
      logic [1:0]      count;
      logic [2:0][2:0] kind;
      logic [2:0][7:0] chr;
   } bundle_type;

   // hex digit decode: bit 4 is valid, bits 3:0 the digit value
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/qspd_front.sv */
`default_nettype none

module qspd_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_mode,
   input  wire logic [7:0]         req_char_in,
   input  wire logic               queue_full,
   output logic                    push,
   output qspd_pkg::bundle_type    push_data
);

   localparam logic [1:0] EscIdle    = 2'd0;
   localparam logic [1:0] EscPercent = 2'd1;
   localparam logic [1:0] EscDigit   = 2'd2;

   localparam logic [7:0] CharEq    = 8'h3D;
   localparam logic [7:0] CharAmp   = 8'h26;
   localparam logic [7:0] CharPlus  = 8'h2B;
   localparam logic [7:0] CharPct   = 8'h25;
   localparam logic [7:0] CharSpace = 8'h20;

   logic                                in_value_ff, in_value_in;
   logic                                pair_open_ff, pair_open_in;
   logic [qspd_pkg::NameLenWidth-1:0]   name_len_ff, name_len_in;
   logic [qspd_pkg::ValueLenWidth-1:0]  value_len_ff, value_len_in;
   logic [1:0]                          escape_phase_ff, escape_phase_in;
   logic [7:0]                          held_digit_ff, held_digit_in;
   logic [4:0]                          hex_in;
   logic [4:0]                          hex_held;
   qspd_pkg::bundle_type                b;
   logic                                accept;

   // pending escape flushed, then the pair end marker
   function automatic qspd_pkg::bundle_type flush_end(input logic [1:0] phase,
                                                       input logic [7:0] held);
      qspd_pkg::bundle_type r;
      r = '0;
      case (phase)
         EscIdle: begin
            r.count   = 2'd1;
            r.kind[0] = qspd_pkg::KindPairEnd;
         end
         EscPercent: begin
            r.count   = 2'd2;
            r.kind[0] = qspd_pkg::KindValue;
            r.chr[0]  = CharPct;
            r.kind[1] = qspd_pkg::KindPairEnd;
         end
         default: begin
            r.count   = 2'd3;
            r.kind[0] = qspd_pkg::KindValue;
            r.chr[0]  = CharPct;
            r.kind[1] = qspd_pkg::KindValue;
            r.chr[1]  = held;
            r.kind[2] = qspd_pkg::KindPairEnd;
         end
      endcase
      return r;
   endfunction

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign hex_in    = qspd_pkg::hex_decode(req_char_in);
   assign hex_held  = qspd_pkg::hex_decode(held_digit_ff);

   // classify the byte and build its result bundle
   always_comb begin
      b               = '0;
      in_value_in     = in_value_ff;
      pair_open_in    = pair_open_ff;
      name_len_in     = name_len_ff;
      value_len_in    = value_len_ff;
      escape_phase_in = escape_phase_ff;
      held_digit_in   = held_digit_ff;
      if (req_mode) begin
         if (in_value_ff) begin
            b = flush_end(escape_phase_ff, held_digit_ff);
         end else if (pair_open_ff) begin
            b.count   = 2'd1;
            b.kind[0] = qspd_pkg::KindPairEmpty;
         end
         in_value_in     = 1'b0;
         pair_open_in    = 1'b0;
         name_len_in     = '0;
         value_len_in    = '0;
         escape_phase_in = EscIdle;
         held_digit_in   = '0;
      end else if (!in_value_ff) begin
         pair_open_in = 1'b1;
         if (req_char_in == CharEq) begin
            in_value_in     = 1'b1;
            value_len_in    = '0;
            escape_phase_in = EscIdle;
            held_digit_in   = '0;
            b.count         = 2'd1;
            b.kind[0]       = qspd_pkg::KindNameEnd;
         end else if (name_len_ff <
                      qspd_pkg::NameLenWidth'(qspd_pkg::NameLimit)) begin
            name_len_in = name_len_ff + qspd_pkg::NameLenWidth'(1);
            b.count     = 2'd1;
            b.kind[0]   = qspd_pkg::KindName;
            b.chr[0]    = req_char_in;
         end
      end else if (req_char_in == CharAmp) begin
         b               = flush_end(escape_phase_ff, held_digit_ff);
         in_value_in     = 1'b0;
         pair_open_in    = 1'b0;
         name_len_in     = '0;
         value_len_in    = '0;
         escape_phase_in = EscIdle;
         held_digit_in   = '0;
      end else if (value_len_ff <
                   qspd_pkg::ValueLenWidth'(qspd_pkg::ValueLimit)) begin
         value_len_in = value_len_ff + qspd_pkg::ValueLenWidth'(1);
         case (escape_phase_ff)
            EscIdle: begin
               if (req_char_in == CharPlus) begin
                  b.count   = 2'd1;
                  b.kind[0] = qspd_pkg::KindValue;
                  b.chr[0]  = CharSpace;
               end else if (req_char_in == CharPct) begin
                  escape_phase_in = EscPercent;
               end else begin
                  b.count   = 2'd1;
                  b.kind[0] = qspd_pkg::KindValue;
                  b.chr[0]  = req_char_in;
               end
            end
            EscPercent: begin
               if (hex_in[4]) begin
                  held_digit_in   = req_char_in;
                  escape_phase_in = EscDigit;
               end else begin
                  b.count         = 2'd2;
                  b.kind[0]       = qspd_pkg::KindValue;
                  b.chr[0]        = CharPct;
                  b.kind[1]       = qspd_pkg::KindValue;
                  b.chr[1]        = req_char_in;
                  escape_phase_in = EscIdle;
               end
            end
            default: begin
               if (hex_in[4]) begin
                  b.count   = 2'd1;
                  b.kind[0] = qspd_pkg::KindValue;
                  b.chr[0]  = {hex_held[3:0], hex_in[3:0]};
               end else begin
                  b.count   = 2'd3;
                  b.kind[0] = qspd_pkg::KindValue;
                  b.chr[0]  = CharPct;
                  b.kind[1] = qspd_pkg::KindValue;
                  b.chr[1]  = held_digit_ff;
                  b.kind[2] = qspd_pkg::KindValue;
                  b.chr[2]  = req_char_in;
               end
               escape_phase_in = EscIdle;
               held_digit_in   = '0;
            end
         endcase
      end
   end

   assign push      = accept && (b.count != 2'd0);
   assign push_data = b;

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_value_ff     <= 1'b0;
         pair_open_ff    <= 1'b0;
         name_len_ff     <= '0;
         value_len_ff    <= '0;
         escape_phase_ff <= EscIdle;
         held_digit_ff   <= '0;
      end else if (accept) begin
         in_value_ff     <= in_value_in;
         pair_open_ff    <= pair_open_in;
         name_len_ff     <= name_len_in;
         value_len_ff    <= value_len_in;
         escape_phase_ff <= escape_phase_in;
         held_digit_ff   <= held_digit_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/qspd_queue.sv */
`default_nettype none

module qspd_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire qspd_pkg::bundle_type   push_data,
   output logic                        full,
   input  wire logic                   pop,
   output logic                        head_valid,
   output qspd_pkg::bundle_type        head_data
);

   qspd_pkg::bundle_type                 entry_ff [qspd_pkg::QueueDepth];
   logic [qspd_pkg::QueuePtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [qspd_pkg::QueuePtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [qspd_pkg::QueueCntWidth-1:0]   count_ff, count_in;

   assign full       = (count_ff == qspd_pkg::QueueCntWidth'(qspd_pkg::QueueDepth));
   assign head_valid = (count_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + qspd_pkg::QueuePtrWidth'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + qspd_pkg::QueuePtrWidth'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + qspd_pkg::QueueCntWidth'(1);
      end else if (pop && !push) begin
         count_in = count_ff - qspd_pkg::QueueCntWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // bundle storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/qspd_back.sv */
`default_nettype none

module qspd_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   head_valid,
   input  wire qspd_pkg::bundle_type   head_data,
   output logic                        pop,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [2:0]                  rsp_kind,
   output logic [7:0]                  rsp_char_out,
   output logic                        rsp_last
);

   logic [1:0] idx_ff, idx_in;
   logic       xfer;
   logic       at_last;

   assign rsp_valid    = head_valid;
   assign at_last      = (idx_ff == 2'(head_data.count - 2'd1));
   assign rsp_kind     = head_data.kind[idx_ff];
   assign rsp_char_out = head_data.chr[idx_ff];
   assign rsp_last     = at_last;
   assign xfer         = rsp_valid && rsp_ready;
   assign pop          = xfer && at_last;

   // walk through the results of the head bundle
   always_comb begin
      idx_in = idx_ff;
      if (xfer) begin
         idx_in = at_last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/query_string_pair_decoder_unit.sv */
// query string pair decoder
//
// req channel: one transfer per query byte (req_mode 0, byte on req_char_in)
// or an end-of-string marker (req_mode 1). rsp channel: name bytes, decoded
// value bytes and pair markers; rsp_last flags the final result of a byte.
// A byte may cause zero to three results.
//
// The front parser takes one byte per cycle while the queue is not full and
// pushes its results as one bundle into a four-entry queue; the back end
// hands them out one per cycle while rsp_ready is high. A byte's results are
// registered in the queue before the back end offers them. Throughput is one
// byte per cycle while each byte yields at most one result; a byte with more
// results holds the output until all are taken, and the queue absorbs short
// bursts of those before req_ready drops. When the receiver stalls, the queue
// fills and req_ready falls once all four entries hold bundles. Reset empties
// the queue and returns the parser to the start of a name with no pair open.
`default_nettype none

module query_string_pair_decoder_unit (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic       req_mode,
   input  wire logic [7:0] req_char_in,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [2:0]      rsp_kind,
   output logic [7:0]      rsp_char_out,
   output logic            rsp_last
);

   logic                 queue_full;
   logic                 push;
   qspd_pkg::bundle_type push_data;
   logic                 pop;
   logic                 head_valid;
   qspd_pkg::bundle_type head_data;

   // parser and classifier
   qspd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_mode    (req_mode),
      .req_char_in (req_char_in),
      .queue_full  (queue_full),
      .push        (push),
      .push_data   (push_data)
   );

   // result bundle queue
   qspd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   // result serialiser
   qspd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (head_valid),
      .head_data    (head_data),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_kind     (rsp_kind),
      .rsp_char_out (rsp_char_out),
      .rsp_last     (rsp_last)
   );

endmodule

`default_nettype wire

/* rtl/core/qspd_checker.sv */
`default_nettype none

module qspd_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [2:0] rsp_kind,
   input wire logic [7:0] rsp_char_out,
   input wire logic       rsp_last
);

   // nothing offered straight after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // a stalled result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped without transfer");

   // markers carry no byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == qspd_pkg::KindNameEnd ||
                    rsp_kind == qspd_pkg::KindPairEnd ||
                    rsp_kind == qspd_pkg::KindPairEmpty) |-> rsp_char_out == 8'd0)
      else $error("marker with non-zero byte");

   // markers always close the results of their byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != qspd_pkg::KindName &&
      rsp_kind != qspd_pkg::KindValue |-> rsp_last)
      else $error("marker not flagged last");

   // name bytes only ever come one per input byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == qspd_pkg::KindName |-> rsp_last)
      else $error("name byte not flagged last");

endmodule

bind query_string_pair_decoder_unit qspd_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_kind     (rsp_kind),
   .rsp_char_out (rsp_char_out),
   .rsp_last     (rsp_last)
);

`default_nettype wire
